### hdl/ofvp_pkg.sv
// Shared constants, codes and control types for the OBJ face vertex parser.
`default_nettype none

package ofvp_pkg;

  localparam int INDEX_BITS_DEF  = 24;
  localparam int MAX_CORNERS_DEF = 4;
  localparam int MIN_CORNERS     = 3;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] KIND_CORNER = 2'd0;
  localparam logic [1:0] KIND_FACE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_VERTS  = 2'd1;
  localparam logic [1:0] ERR_MALFORMED = 2'd2;
  localparam logic [1:0] ERR_RANGE     = 2'd3;

  typedef enum logic [4:0] {
    PH_V      = 5'b00001,
    PH_T      = 5'b00010,
    PH_N      = 5'b00100,
    PH_SLASH  = 5'b01000,
    PH_IGNORE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } q_ctrl_t;

  typedef struct packed {
    logic not_empty;
    logic room_two;
  } q_stat_t;

endpackage

`default_nettype wire

### hdl/ofvp_channels.sv
// Valid/ready channel interfaces for face characters in and parse results out.
`default_nettype none

interface ofvp_char_if
  import ofvp_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [7:0]            char_code;
  logic                  end_of_line;
  logic [INDEX_BITS-1:0] vertex_count;
  logic [INDEX_BITS-1:0] texcoord_count;
  logic [INDEX_BITS-1:0] normal_count;

  modport source (
    output valid, char_code, end_of_line, vertex_count, texcoord_count, normal_count,
    input  ready
  );
  modport sink (
    input  valid, char_code, end_of_line, vertex_count, texcoord_count, normal_count,
    output ready
  );
endinterface

interface ofvp_res_if
  import ofvp_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [1:0]            corner;
  logic [INDEX_BITS-1:0] position_index;
  logic [INDEX_BITS-1:0] uv_index;
  logic                  has_uv;
  logic [INDEX_BITS-1:0] norm_index;
  logic                  has_norm;
  logic [2:0]            corner_total;
  logic [1:0]            error_code;
  logic                  line_done;

  modport source (
    output valid, kind, corner, position_index, uv_index, has_uv, norm_index, has_norm,
           corner_total, error_code, line_done,
    input  ready
  );
  modport sink (
    input  valid, kind, corner, position_index, uv_index, has_uv, norm_index, has_norm,
           corner_total, error_code, line_done,
    output ready
  );
endinterface

`default_nettype wire

### hdl/ofvp_res_fifo.sv
// Four-entry result queue taking up to two words per cycle, one out per cycle.
`default_nettype none

module ofvp_res_fifo
  import ofvp_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  q_ctrl_t          ctrl,
  input  logic [WIDTH-1:0] data_a,
  input  logic [WIDTH-1:0] data_b,
  input  logic             pop,
  output q_stat_t          stat,
  output logic [WIDTH-1:0] head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] wr_ptr_b;
  logic [CNT_W-1:0] n_push;
  logic             do_pop;

  assign do_pop   = pop && (count != '0);
  assign wr_ptr_b = wr_ptr + PTR_W'(1);
  assign n_push   = CNT_W'(ctrl.push_a) + CNT_W'(ctrl.push_b);

  always_comb begin
    count_next = count + n_push - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PTR_W-1:0];
      rd_ptr <= rd_ptr + PTR_W'(do_pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (ctrl.push_b) begin
      mem[wr_ptr_b] <= data_b;
    end
  end

  assign head           = mem[rd_ptr];
  assign stat.not_empty = (count != '0);
  assign stat.room_two  = (count <= CNT_W'(DEPTH - 2));

endmodule

`default_nettype wire

### hdl/obj_face_vertex_parser.sv
// OBJ face line parser: one character per word in, corner/face/error words out.
// With an empty queue, a word's first result is on res_out the next cycle; a second follows once the first is popped.
// Throughput: one character per cycle while ready; a character yields zero, one or two results.
// char_in.ready drops only while the four-entry result queue has under two free slots.
// Reset (rst, synchronous): parser returns to the start of a line, queue empties.
`default_nettype none

module obj_face_vertex_parser
  import ofvp_pkg::*;
#(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ofvp_char_if.sink     char_in,
  ofvp_res_if.source    res_out
);

  localparam int ACC_W = INDEX_BITS + 1;
  localparam int MUL_W = ACC_W + 4;
  localparam int CD_W  = 3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            corner;
    logic [INDEX_BITS-1:0] pos;
    logic [INDEX_BITS-1:0] uv;
    logic                  has_uv;
    logic [INDEX_BITS-1:0] norm;
    logic                  has_norm;
    logic [2:0]            total;
    logic [1:0]            err;
    logic                  done;
  } res_t;

  // parser state
  phase_t                phase;
  logic [ACC_W-1:0]      number_accum;
  logic                  number_negative;
  logic                  digit_seen;
  logic                  sign_taken;
  logic                  range_bad;
  logic [INDEX_BITS-1:0] held_position;
  logic [INDEX_BITS-1:0] held_uv;
  logic                  held_uv_valid;
  logic [CD_W-1:0]       corners_done;
  logic                  line_closed;

  phase_t                phase_next;
  logic [ACC_W-1:0]      accum_next;
  logic                  negative_next;
  logic                  digit_next;
  logic                  sign_next;
  logic                  range_bad_next;
  logic [INDEX_BITS-1:0] held_position_next;
  logic [INDEX_BITS-1:0] held_uv_next;
  logic                  held_uv_valid_next;
  logic [CD_W-1:0]       corners_next;
  logic                  closed_next;

  logic                  accept;
  logic [7:0]            ch;
  logic                  eol;
  logic                  is_digit;
  logic                  is_ws;
  logic                  is_sign;
  logic                  is_slash;
  phase_t                comp;

  logic [MUL_W-1:0]      acc_mul;
  logic [ACC_W-1:0]      acc_d;
  logic [INDEX_BITS-1:0] fin_count;
  logic [ACC_W-1:0]      cnt_ext;
  logic [ACC_W-1:0]      fin_diff;
  logic [INDEX_BITS-1:0] fin_val;
  logic                  fin_bad;

  logic                  tc_end;
  logic                  tc_mal;
  logic                  do_end;
  logic                  do_mal;
  logic [CD_W-1:0]       cd_inc;

  logic                  cor_emit;
  logic                  cls_emit;
  res_t                  cor_res;
  res_t                  cls_res;
  res_t                  res_a;
  res_t                  head_res;

  q_ctrl_t               q_ctrl;
  q_stat_t               q_stat;
  logic [$bits(res_t)-1:0] head_bits;

  assign accept = char_in.valid && char_in.ready;
  assign ch     = char_in.char_code;
  assign eol    = char_in.end_of_line;

  assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
  assign is_ws    = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_slash = (ch == CH_SLASH);
  assign comp     = (phase == PH_SLASH) ? PH_T : phase;
  assign cd_inc   = corners_done + CD_W'(1);

  // decimal accumulate with saturation
  always_comb begin
    acc_mul = (MUL_W'(number_accum) << 3) + (MUL_W'(number_accum) << 1)
            + MUL_W'(ch[3:0]);
    if (acc_mul[MUL_W-1:ACC_W] != '0) begin
      acc_d = '1;
    end else begin
      acc_d = acc_mul[ACC_W-1:0];
    end
    if (!is_digit) begin
      acc_d = number_accum;
    end
  end

  // index resolution for the number just ended
  always_comb begin
    case (comp)
      PH_T:    fin_count = char_in.texcoord_count;
      PH_N:    fin_count = char_in.normal_count;
      default: fin_count = char_in.vertex_count;
    endcase
    cnt_ext = {1'b0, fin_count};
    if (number_negative && (acc_d != '0)) begin
      fin_diff = cnt_ext - acc_d;
      fin_bad  = (acc_d > cnt_ext);
    end else begin
      fin_diff = acc_d - ACC_W'(1);
      fin_bad  = (acc_d == '0) || (fin_diff >= cnt_ext);
    end
    fin_val = fin_diff[INDEX_BITS-1:0];
  end

  always_comb begin
    phase_next         = phase;
    accum_next         = number_accum;
    negative_next      = number_negative;
    digit_next         = digit_seen;
    sign_next          = sign_taken;
    range_bad_next     = range_bad;
    held_position_next = held_position;
    held_uv_next       = held_uv;
    held_uv_valid_next = held_uv_valid;
    corners_next       = corners_done;
    closed_next        = line_closed;
    tc_end             = 1'b0;
    tc_mal             = 1'b0;
    do_end             = 1'b0;
    do_mal             = 1'b0;
    cor_emit           = 1'b0;
    cls_emit           = 1'b0;
    cor_res            = '0;
    cls_res            = '0;
    cls_res.kind       = KIND_ERROR;
    cls_res.done       = 1'b1;
    cor_res.kind       = KIND_CORNER;
    cor_res.corner     = corners_done[1:0];

    if (!line_closed) begin
      if (char_in.vertex_count == '0) begin
        cls_emit    = 1'b1;
        cls_res.err = ERR_NO_VERTS;
        closed_next = 1'b1;
      end else begin
        if (phase != PH_IGNORE) begin
          if (phase == PH_SLASH && is_slash) begin
            phase_next = PH_N;
          end else begin
            if (phase == PH_SLASH) begin
              phase_next = PH_T;
            end
            if (is_digit) begin
              accum_next = acc_d;
              digit_next = 1'b1;
            end else if (!digit_seen) begin
              if (is_ws && !sign_taken) begin
                phase_next = phase_next;
              end else if (is_sign && !sign_taken) begin
                sign_next     = 1'b1;
                negative_next = (ch == CH_MINUS);
              end else begin
                tc_mal = 1'b1;
              end
            end else if (is_ws) begin
              tc_end = 1'b1;
            end else if (is_slash && comp == PH_V) begin
              held_position_next = fin_val;
              range_bad_next     = range_bad | fin_bad;
              accum_next         = '0;
              negative_next      = 1'b0;
              digit_next         = 1'b0;
              sign_next          = 1'b0;
              phase_next         = PH_SLASH;
            end else if (is_slash && comp == PH_T) begin
              held_uv_next       = fin_val;
              held_uv_valid_next = 1'b1;
              range_bad_next     = range_bad | fin_bad;
              accum_next         = '0;
              negative_next      = 1'b0;
              digit_next         = 1'b0;
              sign_next          = 1'b0;
              phase_next         = PH_N;
            end else begin
              tc_mal = 1'b1;
            end
          end
        end

        // end of line closes an open token
        do_end = tc_end;
        do_mal = tc_mal;
        if (eol && !tc_end && !tc_mal) begin
          if ((phase_next == PH_V || phase_next == PH_T || phase_next == PH_N)
              && digit_next) begin
            do_end = 1'b1;
          end else if (phase_next != PH_IGNORE && !(phase_next == PH_V && !sign_next)) begin
            do_mal = 1'b1;
          end
        end

        if (do_end) begin
          accum_next    = '0;
          negative_next = 1'b0;
          digit_next    = 1'b0;
          sign_next     = 1'b0;
          cor_res.pos      = held_position;
          cor_res.uv       = held_uv_valid ? held_uv : '0;
          cor_res.has_uv   = held_uv_valid;
          if (comp == PH_N) begin
            cor_res.norm     = fin_val;
            cor_res.has_norm = 1'b1;
          end else if (comp == PH_V) begin
            cor_res.pos = fin_val;
          end else begin
            cor_res.uv     = fin_val;
            cor_res.has_uv = 1'b1;
          end
          if (range_bad || fin_bad) begin
            range_bad_next = 1'b1;
            closed_next    = 1'b1;
            cls_emit       = 1'b1;
            cls_res.err    = ERR_RANGE;
          end else begin
            cor_emit           = 1'b1;
            corners_next       = cd_inc;
            held_uv_valid_next = 1'b0;
            held_position_next = '0;
            phase_next         = (cd_inc >= CD_W'(MAX_CORNERS)) ? PH_IGNORE : PH_V;
          end
        end

        if (do_mal) begin
          if (corners_done < CD_W'(MIN_CORNERS)) begin
            closed_next = 1'b1;
            cls_emit    = 1'b1;
            cls_res.err = ERR_MALFORMED;
          end else begin
            phase_next     = PH_IGNORE;
            accum_next     = '0;
            negative_next  = 1'b0;
            digit_next     = 1'b0;
            sign_next      = 1'b0;
            range_bad_next = 1'b0;
          end
        end

        if (eol && !closed_next) begin
          closed_next = 1'b1;
          cls_emit    = 1'b1;
          if (corners_next < CD_W'(MIN_CORNERS)) begin
            cls_res.err = ERR_MALFORMED;
          end else begin
            cls_res.kind  = KIND_FACE;
            cls_res.total = corners_next;
          end
        end
      end
    end

    if (eol) begin
      phase_next         = PH_V;
      accum_next         = '0;
      negative_next      = 1'b0;
      digit_next         = 1'b0;
      sign_next          = 1'b0;
      range_bad_next     = 1'b0;
      held_position_next = '0;
      held_uv_valid_next = 1'b0;
      corners_next       = '0;
      closed_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_V;
      number_accum    <= '0;
      number_negative <= 1'b0;
      digit_seen      <= 1'b0;
      sign_taken      <= 1'b0;
      range_bad       <= 1'b0;
      held_position   <= '0;
      held_uv_valid   <= 1'b0;
      corners_done    <= '0;
      line_closed     <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      number_accum    <= accum_next;
      number_negative <= negative_next;
      digit_seen      <= digit_next;
      sign_taken      <= sign_next;
      range_bad       <= range_bad_next;
      held_position   <= held_position_next;
      held_uv_valid   <= held_uv_valid_next;
      corners_done    <= corners_next;
      line_closed     <= closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_uv <= held_uv_next;
    end
  end

  assign res_a         = cor_emit ? cor_res : cls_res;
  assign q_ctrl.push_a = accept && (cor_emit || cls_emit);
  assign q_ctrl.push_b = accept && cor_emit && cls_emit;

  ofvp_res_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (q_ctrl),
    .data_a (res_a),
    .data_b (cls_res),
    .pop    (res_out.ready),
    .stat   (q_stat),
    .head   (head_bits)
  );

  assign head_res      = head_bits;
  assign char_in.ready = q_stat.room_two;

  assign res_out.valid          = q_stat.not_empty;
  assign res_out.kind           = head_res.kind;
  assign res_out.corner         = head_res.corner;
  assign res_out.position_index = head_res.pos;
  assign res_out.uv_index       = head_res.uv;
  assign res_out.has_uv         = head_res.has_uv;
  assign res_out.norm_index     = head_res.norm;
  assign res_out.has_norm       = head_res.has_norm;
  assign res_out.corner_total   = head_res.total;
  assign res_out.error_code     = head_res.err;
  assign res_out.line_done      = head_res.done;

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_ctrl.push_a |-> (char_in.valid && char_in.ready))
    else $error("result pushed without an accepted word");

  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && line_closed) |-> !q_ctrl.push_a)
    else $error("closed line produced a result");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && eol) |=> (corners_done == '0 && !line_closed && !held_uv_valid))
    else $error("line state not cleared after end of line");

  a_corner_bound: assert property (@(posedge clk) disable iff (rst)
    corners_done <= CD_W'(MAX_CORNERS))
    else $error("corner count past limit");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking bench for the OBJ face vertex parser: random and directed face lines scored word by word.
`timescale 1ns / 100ps

module testbench;
  import ofvp_pkg::*;

  localparam int IW = INDEX_BITS_DEF;
  localparam logic [IW:0] TEX_NONE = '1;
  localparam logic [63:0] ACC_LIMIT = (64'd1 << (IW + 1)) - 64'd1;
  localparam logic [IW-1:0] COUNT_MAX = '1;
  localparam int PHASE_WORDS = 220;

  typedef struct packed {
    logic [7:0]    code;
    logic          eol;
    logic [IW-1:0] vc;
    logic [IW-1:0] tc;
    logic [IW-1:0] nc;
  } char_word_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [1:0]    corner;
    logic [IW-1:0] position_index;
    logic [IW-1:0] uv_index;
    logic          has_uv;
    logic [IW-1:0] norm_index;
    logic          has_norm;
    logic [2:0]    corner_total;
    logic [1:0]    error_code;
    logic          line_done;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ofvp_char_if #(.INDEX_BITS(IW)) char_ch ();
  ofvp_res_if  #(.INDEX_BITS(IW)) res_ch ();

  obj_face_vertex_parser #(
    .INDEX_BITS(IW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .char_in(char_ch),
    .res_out(res_ch)
  );

  // parser state mirror
  phase_t        parse_ph;
  logic [IW:0]   num_acc;
  logic          num_neg;
  logic          digit_seen;
  logic          sign_taken;
  logic          range_bad;
  logic          line_closed;
  logic [IW-1:0] held_pos;
  logic [IW:0]   held_tex;
  logic [2:0]    corners_done;
  logic [IW-1:0] cnt_v;
  logic [IW-1:0] cnt_t;
  logic [IW-1:0] cnt_n;

  parse_result_t expected_results[$];
  char_word_t    pending[$];
  logic [7:0]    line_buf[$];

  int words_queued = 0;
  int words_accepted = 0;
  int lines_queued = 0;
  int failures = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int corners_seen = 0;
  int faces_seen = 0;
  int err_seen[4] = '{0, 0, 0, 0};

  function automatic void clear_number();
    num_acc = '0;
    num_neg = 1'b0;
    digit_seen = 1'b0;
    sign_taken = 1'b0;
  endfunction

  function automatic void reset_line();
    parse_ph = PH_V;
    clear_number();
    range_bad = 1'b0;
    held_pos = '0;
    held_tex = TEX_NONE;
    corners_done = '0;
    line_closed = 1'b0;
  endfunction

  function automatic void close_error(input logic [1:0] code);
    parse_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.line_done = 1'b1;
    line_closed = 1'b1;
    expected_results.push_back(r);
  endfunction

  function automatic logic [IW-1:0] close_number(input phase_t p);
    logic [63:0]   acc;
    logic [63:0]   cnt;
    logic [IW-1:0] val;
    acc = 64'(num_acc);
    cnt = 64'((p == PH_V) ? cnt_v : (p == PH_T) ? cnt_t : cnt_n);
    val = '0;
    if (num_neg && acc != 0) begin
      if (acc > cnt) range_bad = 1'b1;
      else val = IW'(cnt - acc);
    end else if (acc == 0 || acc - 1 >= cnt) begin
      range_bad = 1'b1;
    end else begin
      val = IW'(acc - 1);
    end
    clear_number();
    return val;
  endfunction

  function automatic void complete_corner(input logic [IW-1:0] nrm, input logic has_n);
    parse_result_t r;
    if (range_bad) begin
      close_error(ERR_RANGE);
      return;
    end
    r = '0;
    r.kind = KIND_CORNER;
    r.corner = corners_done[1:0];
    r.position_index = held_pos;
    r.has_uv = (held_tex != TEX_NONE);
    r.uv_index = r.has_uv ? held_tex[IW-1:0] : '0;
    r.norm_index = nrm;
    r.has_norm = has_n;
    expected_results.push_back(r);
    corners_done++;
    held_tex = TEX_NONE;
    held_pos = '0;
    parse_ph = (corners_done >= 3'(MAX_CORNERS_DEF)) ? PH_IGNORE : PH_V;
  endfunction

  function automatic void end_token(input phase_t p);
    logic [IW-1:0] v;
    v = close_number(p);
    if (p == PH_N) begin
      complete_corner(v, 1'b1);
    end else begin
      if (p == PH_V) held_pos = v;
      else held_tex = {1'b0, v};
      complete_corner('0, 1'b0);
    end
  endfunction

  // bad token: fatal for the first three corners, turns a quad into a triangle
  function automatic void malformed();
    if (corners_done < 3'(MIN_CORNERS)) begin
      close_error(ERR_MALFORMED);
    end else begin
      parse_ph = PH_IGNORE;
      clear_number();
      range_bad = 1'b0;
    end
  endfunction

  function automatic void predict_word(input char_word_t w);
    parse_result_t r;
    logic [7:0]    c;
    logic          is_ws;
    logic          is_digit;
    logic          held;
    logic [63:0]   grown;
    c = w.code;
    is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    is_digit = (c >= CH_ZERO && c <= CH_NINE);
    cnt_v = w.vc;
    cnt_t = w.tc;
    cnt_n = w.nc;
    if (!line_closed) begin
      if (w.vc == '0) begin
        close_error(ERR_NO_VERTS);
      end else begin
        if (parse_ph != PH_IGNORE) begin
          held = 1'b0;
          if (parse_ph == PH_SLASH) begin
            if (c == CH_SLASH) begin
              parse_ph = PH_N;
              held = 1'b1;
            end else begin
              parse_ph = PH_T;
            end
          end
          if (!held) begin
            if (is_digit) begin
              grown = 64'(num_acc) * 64'd10 + 64'(c - CH_ZERO);
              num_acc = (grown > ACC_LIMIT) ? ACC_LIMIT[IW:0] : grown[IW:0];
              digit_seen = 1'b1;
            end else if (!digit_seen) begin
              if ((c == CH_PLUS || c == CH_MINUS) && !sign_taken) begin
                sign_taken = 1'b1;
                num_neg = (c == CH_MINUS);
              end else if (!is_ws || sign_taken) begin
                malformed();
              end
            end else if (is_ws) begin
              end_token(parse_ph);
            end else if (c == CH_SLASH && parse_ph == PH_V) begin
              held_pos = close_number(PH_V);
              parse_ph = PH_SLASH;
            end else if (c == CH_SLASH && parse_ph == PH_T) begin
              held_tex = {1'b0, close_number(PH_T)};
              parse_ph = PH_N;
            end else begin
              malformed();
            end
          end
        end
        if (w.eol && !line_closed) begin
          if ((parse_ph == PH_V || parse_ph == PH_T || parse_ph == PH_N) && digit_seen) begin
            end_token(parse_ph);
          end else if (parse_ph != PH_IGNORE && !(parse_ph == PH_V && !sign_taken)) begin
            malformed();
          end
          if (!line_closed) begin
            if (corners_done < 3'(MIN_CORNERS)) begin
              close_error(ERR_MALFORMED);
            end else begin
              line_closed = 1'b1;
              r = '0;
              r.kind = KIND_FACE;
              r.corner_total = corners_done;
              r.line_done = 1'b1;
              expected_results.push_back(r);
            end
          end
        end
      end
    end
    if (w.eol) reset_line();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // line building
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_ws(input int unsigned n);
    repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
  endfunction

  function automatic void push_line(input logic [IW-1:0] vc, input logic [IW-1:0] tc,
                                    input logic [IW-1:0] nc, input int zero_pct);
    char_word_t w;
    for (int i = 0; i < line_buf.size(); i++) begin
      w.code = line_buf[i];
      w.eol = (i == line_buf.size() - 1);
      w.vc = ($urandom_range(99) < zero_pct) ? '0 : vc;
      w.tc = tc;
      w.nc = nc;
      pending.push_back(w);
      words_queued++;
    end
    line_buf.delete();
    lines_queued++;
  endfunction

  function automatic void add_number(input logic [IW-1:0] count);
    int unsigned pick;
    int unsigned top;
    int unsigned digits;
    logic        neg;
    logic [31:0] mag;
    pick = $urandom_range(99);
    top = (count == '0) ? 1 : 32'(count);
    neg = (pick >= 55 && pick < 75) || (pick >= 75 && $urandom_range(1) == 1);
    mag = $urandom_range(top, 1);
    if (pick >= 75 && pick < 82) mag = 0;
    else if (pick >= 82 && pick < 90) mag = 32'(count) + 1;
    else if (pick >= 96) mag = $urandom_range(30);
    if (neg) line_buf.push_back(CH_MINUS);
    else if ($urandom_range(9) == 0) line_buf.push_back(CH_PLUS);
    if ($urandom_range(19) == 0) line_buf.push_back(CH_ZERO);
    if (pick >= 90 && pick < 96) begin
      digits = $urandom_range(12, 8);
      repeat (digits) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    end else begin
      add_text($sformatf("%0d", mag));
    end
  endfunction

  function automatic void add_corner(input logic [IW-1:0] vc, input logic [IW-1:0] tc,
                                     input logic [IW-1:0] nc);
    int unsigned form;
    form = $urandom_range(3);
    add_number(vc);
    if (form == 1 || form == 3) begin
      line_buf.push_back(CH_SLASH);
      if ($urandom_range(9) == 0) add_ws(1);
      add_number(tc);
    end
    if (form == 2) begin
      line_buf.push_back(CH_SLASH);
      line_buf.push_back(CH_SLASH);
      add_number(nc);
    end
    if (form == 3) begin
      line_buf.push_back(CH_SLASH);
      if ($urandom_range(9) == 0) add_ws(1);
      add_number(nc);
    end
  endfunction

  function automatic void add_random_line();
    int unsigned   r;
    int unsigned   corners;
    int unsigned   pos;
    logic [IW-1:0] vc;
    logic [IW-1:0] tc;
    logic [IW-1:0] nc;
    r = $urandom_range(99);
    if (r < 60) begin
      vc = IW'($urandom_range(30, 1));
      tc = IW'($urandom_range(30, 1));
      nc = IW'($urandom_range(30, 1));
    end else if (r < 75) begin
      vc = IW'($urandom_range(COUNT_MAX, 1));
      tc = IW'($urandom_range(COUNT_MAX, 1));
      nc = IW'($urandom_range(COUNT_MAX, 1));
    end else if (r < 82) begin
      vc = COUNT_MAX;
      tc = COUNT_MAX;
      nc = COUNT_MAX;
    end else if (r < 88) begin
      vc = IW'($urandom_range(20, 1));
      tc = $urandom_range(1) ? '0 : IW'($urandom_range(20, 1));
      nc = (tc != '0) ? '0 : IW'($urandom_range(20));
    end else if (r < 92) begin
      vc = '0;
      tc = IW'($urandom_range(20));
      nc = IW'($urandom_range(20));
    end else begin
      vc = IW'($urandom);
      tc = IW'($urandom);
      nc = IW'($urandom);
    end
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(4) == 0) add_ws($urandom_range(2, 1));
      r = $urandom_range(99);
      corners = (r < 10) ? $urandom_range(2, 1) :
                (r < 85) ? $urandom_range(4, 3) : $urandom_range(6, 5);
      for (int i = 0; i < corners; i++) begin
        if (i != 0) add_ws($urandom_range(2, 1));
        add_corner(vc, tc, nc);
      end
      if ($urandom_range(3) == 0) add_ws($urandom_range(2, 1));
      if ($urandom_range(99) < 15) begin
        pos = $urandom_range(line_buf.size() - 1);
        if ($urandom_range(1)) line_buf[pos] = 8'($urandom_range(255));
        else line_buf.insert(pos, 8'($urandom_range(255)));
      end
    end
    push_line(vc, tc, nc, ($urandom_range(9) == 0) ? 3 : 0);
  endfunction

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin : drive
    char_word_t w;
    char_word_t seen;
    if (rst) begin
      char_ch.valid <= 1'b0;
      char_ch.char_code <= '0;
      char_ch.end_of_line <= 1'b0;
      char_ch.vertex_count <= '0;
      char_ch.texcoord_count <= '0;
      char_ch.normal_count <= '0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        seen.code = char_ch.char_code;
        seen.eol = char_ch.end_of_line;
        seen.vc = char_ch.vertex_count;
        seen.tc = char_ch.texcoord_count;
        seen.nc = char_ch.normal_count;
        predict_word(seen);
        words_accepted++;
      end
      if (!char_ch.valid || char_ch.ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          w = pending.pop_front();
          char_ch.char_code <= w.code;
          char_ch.end_of_line <= w.eol;
          char_ch.vertex_count <= w.vc;
          char_ch.texcoord_count <= w.tc;
          char_ch.normal_count <= w.nc;
          char_ch.valid <= 1'b1;
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : score
    parse_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: kind %0d", res_ch.kind);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(res_ch.kind));
          check_field("corner", 32'(want.corner), 32'(res_ch.corner));
          check_field("position_index", 32'(want.position_index),
                      32'(res_ch.position_index));
          check_field("uv_index", 32'(want.uv_index), 32'(res_ch.uv_index));
          check_field("has_uv", 32'(want.has_uv), 32'(res_ch.has_uv));
          check_field("norm_index", 32'(want.norm_index), 32'(res_ch.norm_index));
          check_field("has_norm", 32'(want.has_norm), 32'(res_ch.has_norm));
          check_field("corner_total", 32'(want.corner_total), 32'(res_ch.corner_total));
          check_field("error_code", 32'(want.error_code), 32'(res_ch.error_code));
          check_field("line_done", 32'(want.line_done), 32'(res_ch.line_done));
          if (want.kind == KIND_CORNER) corners_seen++;
          else if (want.kind == KIND_FACE) faces_seen++;
          else err_seen[want.error_code]++;
        end
      end
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    int base;
    reset_line();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct = 38;
          stall_pct = 38;
        end
      endcase
      if (ph == 0) begin
        // quad at full counts with a fifth corner dropped, no vertices,
        // bad first-face token, zero index
        add_text("1/1/1 -1//1 3/1 4 5");
        push_line(COUNT_MAX, COUNT_MAX, COUNT_MAX, 0);
        add_text("7");
        push_line('0, IW'(1), IW'(1), 0);
        add_text("1 x");
        push_line(IW'(3), IW'(3), IW'(3), 0);
        add_text("1 2 0");
        push_line(IW'(3), IW'(3), IW'(3), 0);
      end
      base = words_queued;
      while (words_queued - base < PHASE_WORDS) add_random_line();
      while (words_accepted != words_queued) @(posedge clk);
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d characters in %0d lines through four flow-control phases.",
             words_accepted, lines_queued);
    $display("Checked %0d corners, %0d faces, errors: %0d no-vertex, %0d malformed, %0d range.",
             corners_seen, faces_seen, err_seen[ERR_NO_VERTS], err_seen[ERR_MALFORMED],
             err_seen[ERR_RANGE]);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("obj_face_vertex_parser: match");
    end else begin
      $display("obj_face_vertex_parser: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("obj_face_vertex_parser: mismatch");
    $finish;
  end

endmodule
